### rtl/btop_pkg.sv
// btop_pkg: shared constants, register codes and controller/datapath structs
// for the binomial tree option pricer. No dependencies.
`default_nettype none

package btop_pkg;

    // Tree size limit and derived index widths
    localparam int MAX_STEPS  = 1024;
    localparam int NODE_DEPTH = MAX_STEPS + 1;
    localparam int IDX_W      = $clog2(NODE_DEPTH);

    // Fixed field widths
    localparam int PRICE_W  = 32;   // Q16.16
    localparam int UP_W     = 32;   // Q2.30
    localparam int DOWN_W   = 31;   // Q1.30
    localparam int WEIGHT_W = 32;   // Q0.32
    localparam int STEP_W   = 11;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STRIKE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_UP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_DOWN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IS_CALL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EARLY_EX    = 3'd7;

    // Reset values
    localparam logic [PRICE_W-1:0]  RST_STRIKE      = 32'd6553600;
    localparam logic [UP_W-1:0]     RST_UP_FACTOR   = 32'd1073741824;
    localparam logic [DOWN_W-1:0]   RST_DOWN_FACTOR = 31'd1073741824;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT      = 32'd2147483648;
    localparam logic [STEP_W-1:0]   RST_STEP_COUNT  = 11'd1024;

    typedef struct packed {
        logic [PRICE_W-1:0]  strike_price;
        logic [UP_W-1:0]     up_factor;
        logic [DOWN_W-1:0]   down_factor;
        logic [WEIGHT_W-1:0] weight_up;
        logic [WEIGHT_W-1:0] weight_down;
        logic [STEP_W-1:0]   step_count;
        logic                is_call;
        logic                early_exercise;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             start;      // latch spot, clear overflow flag
        logic             base_wr;    // store level base at idx
        logic             base_step;  // base times down factor
        logic             base_rd;    // fetch level base at lvl
        logic             load_spot;  // node spot from fetched base
        logic             node_rd;    // fetch children idx, idx+1
        logic             mul_up1;    // first up multiply
        logic             mul_up2;    // second up multiply
        logic             capture;    // register products and payoff
        logic             leaf;       // current level is the leaf level
        logic             last;       // root node, no write-back
        logic             load_out;   // move result to output register
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] lvl;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

### rtl/btop_cfg_if.sv
// btop_cfg_if: configuration write channel (valid/ready, index, data).
// Depends on btop_pkg.
`default_nettype none

interface btop_cfg_if
    import btop_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/btop_spot_if.sv
// btop_spot_if: input channel carrying one spot price per item.
// Depends on btop_pkg.
`default_nettype none

interface btop_spot_if
    import btop_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] spot;

    modport source (output valid, output spot, input ready);
    modport sink   (input valid, input spot, output ready);
endinterface

`default_nettype wire

### rtl/btop_price_if.sv
// btop_price_if: result channel carrying option price and saturation flag.
// Depends on btop_pkg.
`default_nettype none

interface btop_price_if
    import btop_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PRICE_W-1:0] price;
    logic               saturated;

    modport source (output valid, output price, output saturated, input ready);
    modport sink   (input valid, input price, input saturated, output ready);
endinterface

`default_nettype wire

### rtl/binomial_tree_option_pricer_unit.sv
// binomial_tree_option_pricer_unit: top level of the binomial tree pricer.
// Depends on btop_pkg, the three channel interfaces, btop_cfg_regs,
// btop_ctrl and btop_datapath.
`default_nettype none

// Prices one option per spot item on a recombining Cox-Ross-Rubinstein tree
// of N = min(step_count, 1024) steps. Software loads strike, up/down factors
// (Q2.30), discounted branch weights (Q0.32), step count, call/put and
// american/european mode; writes are taken at any time but should only be
// made between items. Per item the block first walks the down-factor chain
// S*d^k for k = 0..N into a level base store, then runs the leaf level and
// the N fold levels. Each level first fetches its base (LVL_RD, LVL_LD),
// then handles each node in NODE_A and NODE_B, as the node spot recurrence
// (two dependent Q2.30 multiplies by u through one shared multiplier) needs
// both, while the two fold products and the exercise compare run alongside.
// Items are taken one at a time; the result sits in an output register, so
// a new spot is accepted while the previous price still waits to be
// collected. The saturated flag is set when any node spot or folded value
// clipped to 0xFFFFFFFF during that item, in either mode. Node values live
// in a 1025-entry store with two read ports and one write port; it needs no
// clearing, as every entry is written before it is read.

module binomial_tree_option_pricer_unit
    import btop_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    btop_cfg_if.sink     cfg,
    btop_spot_if.sink    spot_ch,
    btop_price_if.source price_ch
);

    cfg_t    settings;
    cmd_t    cmd;
    status_t status;

    // Register file
    btop_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .settings (settings)
    );

    // Sequencer: base chain, leaf level, fold levels, result hand-off
    btop_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_count (settings.step_count),
        .in_valid   (spot_ch.valid),
        .in_ready   (spot_ch.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Arithmetic, node stores and output register
    btop_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .settings  (settings),
        .cmd       (cmd),
        .status    (status),
        .spot_in   (spot_ch.spot),
        .out_valid (price_ch.valid),
        .out_ready (price_ch.ready),
        .price     (price_ch.price),
        .saturated (price_ch.saturated)
    );

endmodule

`default_nettype wire

### rtl/btop_cfg_regs.sv
// btop_cfg_regs: configuration register file, always ready.
// Depends on btop_pkg and btop_cfg_if.
`default_nettype none

module btop_cfg_regs
    import btop_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    btop_cfg_if.sink    cfg,
    output cfg_t        settings
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign settings  = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_STRIKE:      cfg_next.strike_price   = cfg.data[PRICE_W-1:0];
                REG_UP_FACTOR:   cfg_next.up_factor      = cfg.data[UP_W-1:0];
                REG_DOWN_FACTOR: cfg_next.down_factor    = cfg.data[DOWN_W-1:0];
                REG_WEIGHT_UP:   cfg_next.weight_up      = cfg.data[WEIGHT_W-1:0];
                REG_WEIGHT_DOWN: cfg_next.weight_down    = cfg.data[WEIGHT_W-1:0];
                REG_STEP_COUNT:  cfg_next.step_count     = cfg.data[STEP_W-1:0];
                REG_IS_CALL:     cfg_next.is_call        = cfg.data[0];
                REG_EARLY_EX:    cfg_next.early_exercise = cfg.data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strike_price   <= RST_STRIKE;
            cfg_reg.up_factor      <= RST_UP_FACTOR;
            cfg_reg.down_factor    <= RST_DOWN_FACTOR;
            cfg_reg.weight_up      <= RST_WEIGHT;
            cfg_reg.weight_down    <= RST_WEIGHT;
            cfg_reg.step_count     <= RST_STEP_COUNT;
            cfg_reg.is_call        <= 1'b0;
            cfg_reg.early_exercise <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### rtl/btop_ctrl.sv
// btop_ctrl: sequencer that walks base chain, leaf level and fold levels.
// Depends on btop_pkg; drives btop_datapath through cmd_t.
`default_nettype none

module btop_ctrl
    import btop_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [STEP_W-1:0]   step_count,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire status_t             status,
    output cmd_t                     cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BASE   = 3'd1;
    localparam logic [2:0] ST_LVL_RD = 3'd2;
    localparam logic [2:0] ST_LVL_LD = 3'd3;
    localparam logic [2:0] ST_NODE_A = 3'd4;
    localparam logic [2:0] ST_NODE_B = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] lvl_reg, lvl_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] n_clamped;
    logic             accept;
    logic             idx_at_end;
    logic             base_at_end;

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign idx_at_end  = (idx_reg == lvl_reg);
    assign base_at_end = (idx_reg == n_reg);

    always_comb
    begin
        if (32'(step_count) > 32'(MAX_STEPS))
            n_clamped = IDX_W'(MAX_STEPS);
        else
            n_clamped = IDX_W'(step_count);
    end

    always_comb
    begin
        cmd           = '0;
        cmd.idx       = idx_reg;
        cmd.lvl       = lvl_reg;
        cmd.leaf      = (lvl_reg == n_reg);
        cmd.last      = idx_at_end && (lvl_reg == '0);
        cmd.start     = accept;
        cmd.base_wr   = (state_reg == ST_BASE);
        cmd.base_step = (state_reg == ST_BASE) && !base_at_end;
        cmd.base_rd   = (state_reg == ST_LVL_RD);
        cmd.load_spot = (state_reg == ST_LVL_LD);
        cmd.node_rd   = (state_reg == ST_NODE_A) && !cmd.leaf;
        cmd.mul_up1   = (state_reg == ST_NODE_A) && !idx_at_end;
        cmd.mul_up2   = (state_reg == ST_NODE_B) && !idx_at_end;
        cmd.capture   = (state_reg == ST_NODE_B);
        cmd.load_out  = (state_reg == ST_FINISH) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        lvl_next   = lvl_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next     = n_clamped;
                    idx_next   = '0;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (base_at_end)
                begin
                    lvl_next   = n_reg;
                    state_next = ST_LVL_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_LVL_RD:
            begin
                idx_next   = '0;
                state_next = ST_LVL_LD;
            end
            ST_LVL_LD:
            begin
                state_next = ST_NODE_A;
            end
            ST_NODE_A:
            begin
                state_next = ST_NODE_B;
            end
            ST_NODE_B:
            begin
                if (!idx_at_end)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_NODE_A;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = ST_LVL_RD;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            lvl_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            lvl_reg   <= lvl_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

### rtl/btop_datapath.sv
// btop_datapath: spot multiplier, level base store, node value store, fold
// arithmetic and output register. Depends on btop_pkg; driven by btop_ctrl.
`default_nettype none

module btop_datapath
    import btop_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               settings,
    input  wire cmd_t               cmd,
    output status_t                 status,
    input  wire logic [PRICE_W-1:0] spot_in,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [PRICE_W-1:0]      price,
    output logic                    saturated
);

    localparam int PROD_W = PRICE_W + UP_W;
    localparam int FOLD_W = PRICE_W + WEIGHT_W;

    // Stores
    logic [PRICE_W-1:0] base_mem [NODE_DEPTH];
    logic [PRICE_W-1:0] node_mem [NODE_DEPTH];

    logic [PRICE_W-1:0] spot_reg;
    logic [PRICE_W-1:0] t_reg;
    logic [PRICE_W-1:0] base_rd_reg;
    logic [PRICE_W-1:0] up_rd_reg;
    logic [PRICE_W-1:0] dn_rd_reg;
    logic [FOLD_W-1:0]  prod_up_reg;
    logic [FOLD_W-1:0]  prod_dn_reg;
    logic [PRICE_W-1:0] pay_reg;
    logic               leaf_reg;
    logic [IDX_W-1:0]   wb_addr_reg;
    logic               wb_pend_reg;
    logic               ovf_reg;
    logic               out_valid_reg;
    logic [PRICE_W-1:0] price_reg;
    logic               sat_reg;

    logic [PRICE_W-1:0] mul_a;
    logic [UP_W-1:0]    mul_f;
    logic [PROD_W-1:0]  mul_p;
    logic               mul_sat;
    logic [PRICE_W-1:0] mul_res;
    logic               mul_used;
    logic [FOLD_W:0]    fold_sum;
    logic               fold_sat;
    logic [PRICE_W-1:0] fold_val;
    logic [PRICE_W-1:0] wb_val;
    logic               wb_sat;
    logic [PRICE_W-1:0] pay_now;
    logic [IDX_W-1:0]   idx_up;

    // Shared Q2.30 multiply, truncated, saturating
    assign mul_a    = cmd.mul_up2 ? t_reg : spot_reg;
    assign mul_f    = cmd.base_step ? {1'b0, settings.down_factor} : settings.up_factor;
    assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_f);
    assign mul_sat  = |mul_p[PROD_W-1:PRICE_W+30];
    assign mul_res  = mul_sat ? '1 : mul_p[PRICE_W+29:30];
    assign mul_used = cmd.base_step || cmd.mul_up1 || cmd.mul_up2;

    // Payoff of the current node spot
    always_comb
    begin
        if (settings.is_call)
            pay_now = (spot_reg > settings.strike_price) ?
                      spot_reg - settings.strike_price : '0;
        else
            pay_now = (settings.strike_price > spot_reg) ?
                      settings.strike_price - spot_reg : '0;
    end

    // Fold: exact sum of both products, keep the upper word
    assign fold_sum = {1'b0, prod_up_reg} + {1'b0, prod_dn_reg};
    assign fold_sat = fold_sum[FOLD_W];
    assign fold_val = fold_sat ? '1 : fold_sum[FOLD_W-1:WEIGHT_W];

    always_comb
    begin
        if (leaf_reg)
            wb_val = pay_reg;
        else if (settings.early_exercise && (pay_reg > fold_val))
            wb_val = pay_reg;
        else
            wb_val = fold_val;
    end

    assign wb_sat = !leaf_reg && fold_sat;
    assign idx_up = cmd.idx + 1'b1;

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign price           = price_reg;
    assign saturated       = sat_reg;

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
            spot_reg <= spot_in;
        else if (cmd.load_spot)
            spot_reg <= base_rd_reg;
        else if (cmd.base_step || cmd.mul_up2)
            spot_reg <= mul_res;

        if (cmd.mul_up1)
            t_reg <= mul_res;

        if (cmd.capture)
        begin
            prod_up_reg <= FOLD_W'(settings.weight_up) * FOLD_W'(up_rd_reg);
            prod_dn_reg <= FOLD_W'(settings.weight_down) * FOLD_W'(dn_rd_reg);
            pay_reg     <= pay_now;
            leaf_reg    <= cmd.leaf;
            wb_addr_reg <= cmd.idx;
        end

        if (cmd.load_out)
        begin
            price_reg <= wb_val;
            sat_reg   <= ovf_reg || wb_sat;
        end
    end

    // Level base store
    always_ff @(posedge clk)
    begin
        if (cmd.base_wr)
            base_mem[cmd.idx] <= spot_reg;
        if (cmd.base_rd)
            base_rd_reg <= base_mem[cmd.lvl];
    end

    // Node value store: one write, two reads
    always_ff @(posedge clk)
    begin
        if (wb_pend_reg)
            node_mem[wb_addr_reg] <= wb_val;
        if (cmd.node_rd)
        begin
            up_rd_reg <= node_mem[idx_up];
            dn_rd_reg <= node_mem[cmd.idx];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_pend_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wb_pend_reg <= cmd.capture && !cmd.last;

            if (cmd.start)
                ovf_reg <= 1'b0;
            else if ((mul_used && mul_sat) || (wb_pend_reg && wb_sat))
                ovf_reg <= 1'b1;

            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire
